@@ sv/chat_pkg.sv @@
// Package for the chained hash accumulate table: sizes, action codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package chat_pkg;

  localparam int unsigned BUCKETS_DEF = 1021;
  localparam int unsigned ENTRIES_DEF = 4096;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input word
    logic hash_step;  // one step of the key reduction
    logic head_rd;    // read bucket head
    logic ent_rd;     // read entry at current position
    logic advance;    // follow chain link
    logic clr_step;   // clear one bucket
    logic clr_start;  // start clear sweep
    logic do_update;  // write hit sum or new entry
    logic set_result; // latch result word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t act;
    logic    hash_done;
    logic    clr_done;
    logic    walk_ok;    // current position is valid and within bounds
    logic    key_match;
  } stat_t;

endpackage

@@ sv/chat_if.sv @@
// Valid/ready channel carrying one word of a generic payload type.
// Depends on nothing.
interface chat_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/chained_hash_accumulate_table.sv @@
// Chained hash accumulate table. One word in, one result word out, one word
// at a time. After reset the bucket valid bits are swept clear one per cycle,
// so the first word is taken only once the sweep is done. The key is reduced
// modulo BUCKETS (reciprocal multiply, subtract, correct), then the chain is
// walked entry by entry (registered read, then compare). A clear sweeps the
// valid bits again and empties the table; the unused action skips the walk
// and returns an empty result.
// Depends on chat_pkg, chat_if, chat_ctrl and chat_data.
module chained_hash_accumulate_table #(
  parameter int unsigned BUCKETS = chat_pkg::BUCKETS_DEF,
  parameter int unsigned ENTRIES = chat_pkg::ENTRIES_DEF
) (
  input logic clk,
  input logic rst,
  chat_if.sink   req,
  chat_if.source rsp
);

  chat_pkg::cmd_t  cmd;
  chat_pkg::stat_t stat;

  chat_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid), .in_ready (req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat, .cmd
  );

  chat_data #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_data (
    .clk, .rst, .cmd, .stat,
    .action    (req.data.action),
    .lookup_key(req.data.lookup_key),
    .add_value (req.data.add_value),
    .route_in  (req.data.route_in),
    .hit       (rsp.data.hit),
    .sum_out   (rsp.data.sum_out),
    .route_out (rsp.data.route_out),
    .table_full(rsp.data.table_full)
  );

`ifndef ASSERT_OFF
  // Never take a word while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("input taken with result pending");
  // Result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
  // Full and hit never together
  a_full_hit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.data.hit && rsp.data.table_full))
    else $error("hit and full together");
`endif

endmodule

@@ sv/chat_ctrl.sv @@
// Controller state machine for the chained hash table.
// Depends on chat_pkg.
module chat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  chat_pkg::stat_t  stat,
  output chat_pkg::cmd_t   cmd
);

  chat_pkg::state_t state, state_next;

  // Hold state; start with a sweep of the bucket valid bits
  always_ff @(posedge clk) begin
    if (rst) state <= chat_pkg::ST_INIT;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      chat_pkg::ST_INIT: if (stat.clr_done) state_next = chat_pkg::ST_IDLE;
      chat_pkg::ST_IDLE: if (in_valid) state_next = chat_pkg::ST_HASH;
      chat_pkg::ST_HASH: begin
        if (stat.act == chat_pkg::ACT_CLEAR) state_next = chat_pkg::ST_CLEAR;
        else if (stat.act == chat_pkg::ACT_NONE) state_next = chat_pkg::ST_DONE;
        else if (stat.hash_done) state_next = chat_pkg::ST_HEAD;
      end
      chat_pkg::ST_HEAD:      state_next = chat_pkg::ST_HEAD_WAIT;
      chat_pkg::ST_HEAD_WAIT: state_next = chat_pkg::ST_READ;
      chat_pkg::ST_READ: begin
        if (stat.walk_ok) state_next = chat_pkg::ST_CHECK;
        else              state_next = chat_pkg::ST_UPDATE;
      end
      chat_pkg::ST_CHECK: begin
        if (stat.key_match) state_next = chat_pkg::ST_UPDATE;
        else                state_next = chat_pkg::ST_READ;
      end
      chat_pkg::ST_CLEAR:  if (stat.clr_done) state_next = chat_pkg::ST_DONE;
      chat_pkg::ST_UPDATE: state_next = chat_pkg::ST_DONE;
      chat_pkg::ST_DONE:   if (out_ready) state_next = chat_pkg::ST_IDLE;
      default:             state_next = chat_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      chat_pkg::ST_INIT:      cmd.clr_step = 1'b1;
      chat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      chat_pkg::ST_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.clr_start = (stat.act == chat_pkg::ACT_CLEAR);
        cmd.set_result = (stat.act == chat_pkg::ACT_NONE);
      end
      chat_pkg::ST_HEAD:      cmd.head_rd = 1'b1;
      chat_pkg::ST_HEAD_WAIT: cmd.ent_rd = 1'b1;
      chat_pkg::ST_READ:      ;
      chat_pkg::ST_CHECK: begin
        cmd.advance = !stat.key_match;
        cmd.ent_rd  = !stat.key_match;
      end
      chat_pkg::ST_CLEAR: begin
        cmd.clr_step   = 1'b1;
        cmd.set_result = stat.clr_done;
      end
      chat_pkg::ST_UPDATE: begin
        cmd.do_update  = 1'b1;
        cmd.set_result = 1'b1;
      end
      chat_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/chat_data.sv @@
// Datapath of the chained hash table: key reduction, bucket and entry
// memories, chain walk registers and result word. Depends on chat_pkg.
module chat_data #(
  parameter int unsigned BUCKETS = chat_pkg::BUCKETS_DEF,
  parameter int unsigned ENTRIES = chat_pkg::ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  chat_pkg::cmd_t       cmd,
  output chat_pkg::stat_t      stat,
  input  logic [1:0]           action,
  input  logic [31:0]          lookup_key,
  input  logic signed [63:0]   add_value,
  input  logic [63:0]          route_in,
  output logic                 hit,
  output logic signed [63:0]   sum_out,
  output logic [63:0]          route_out,
  output logic                 table_full
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int KSTEPS = 3;
  localparam int SW = $clog2(KSTEPS + 1);
  localparam logic [31:0] BMOD = 32'(BUCKETS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [CW-1:0] EMAX = CW'(ENTRIES);

  // Input word
  chat_pkg::action_t act;
  logic [31:0]        key;
  logic [63:0]        val;
  logic [63:0]        rte;

  // Key reduction: quotient estimate, remainder and step count
  logic [31:0]   quo;
  logic [31:0]   rem;
  logic [SW-1:0] kstep;
  logic [63:0]   recip_prod;
  logic [63:0]   quo_prod;
  assign recip_prod = 64'(key) * 64'(RECIP);
  assign quo_prod   = 64'(quo) * 64'(BMOD);

  // Memories
  logic [EW-1:0] head_mem [BUCKETS];
  logic          head_vld [BUCKETS];
  logic [EW:0]   link_mem [ENTRIES];  // top bit: link valid
  logic [31:0]   key_mem  [ENTRIES];
  logic [63:0]   sum_mem  [ENTRIES];
  logic [63:0]   rte_mem  [ENTRIES];

  logic [BW-1:0] bkt;
  logic [CW-1:0] count;
  logic [CW-1:0] steps;
  logic [EW:0]   pos;      // top bit: position valid
  logic [EW:0]   pos_rd;
  logic [EW:0]   head_q;
  logic [EW:0]   link_q;
  logic [31:0]   key_q;
  logic [63:0]   sum_q;
  logic [63:0]   rte_q;
  logic [BW-1:0] clr_idx;
  logic          found;
  logic          ins_hit;
  logic          ins_new;

  assign bkt = rem[BW-1:0];

  // Only an insert writes entries: add to a matched sum, or link in a new entry
  assign ins_hit = cmd.do_update && (act == chat_pkg::ACT_INSERT) && found;
  assign ins_new = cmd.do_update && (act == chat_pkg::ACT_INSERT) && !found &&
                   (count < EMAX);

  // Capture word, then reduce the key modulo BUCKETS: estimate the quotient
  // by reciprocal multiply (low by at most one), subtract, correct once
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= chat_pkg::action_t'(action);
      key   <= lookup_key;
      val   <= add_value;
      rte   <= route_in;
      kstep <= '0;
    end else if (cmd.hash_step && kstep != SW'(KSTEPS)) begin
      case (kstep)
        SW'(0):  quo <= recip_prod[63:32];
        SW'(1):  rem <= key - quo_prod[31:0];
        default: rem <= (rem >= BMOD) ? rem - BMOD : rem;
      endcase
      kstep <= kstep + SW'(1);
    end
  end

  // Bucket heads with valid bits
  always_ff @(posedge clk) begin
    if (cmd.head_rd) head_q <= {head_vld[bkt], head_mem[bkt]};
    if (ins_new) begin
      head_mem[bkt] <= count[EW-1:0];
    end
  end

  // Valid bits are swept clear one per cycle, after reset and on clear
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      head_vld[clr_idx] <= 1'b0;
    end else if (ins_new) begin
      head_vld[bkt] <= 1'b1;
    end
  end

  // Entry memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.ent_rd) begin
      link_q <= link_mem[pos_rd[EW-1:0]];
      key_q  <= key_mem[pos_rd[EW-1:0]];
      sum_q  <= sum_mem[pos_rd[EW-1:0]];
      rte_q  <= rte_mem[pos_rd[EW-1:0]];
    end
    if (ins_hit) begin
      sum_mem[pos[EW-1:0]] <= sum_q + val;
    end else if (ins_new) begin
      key_mem[count[EW-1:0]]  <= key;
      sum_mem[count[EW-1:0]]  <= val;
      rte_mem[count[EW-1:0]]  <= rte;
      link_mem[count[EW-1:0]] <= head_q;
    end
  end

  // Read address: head on first read, next link after a miss
  assign pos_rd = cmd.advance ? link_q : head_q;

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      steps <= '0;
      found <= 1'b0;
    end else if (cmd.ent_rd) begin
      pos <= pos_rd;
      if (cmd.advance) steps <= steps + CW'(1);
    end else if (stat.walk_ok && stat.key_match && !cmd.do_update) begin
      found <= 1'b1;
    end
  end

  // Entry count and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      clr_idx <= '0;
    end else if (cmd.clr_start) begin
      count   <= '0;
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + BW'(1);
    end else if (ins_new) begin
      count <= count + CW'(1);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      hit <= 1'b0; sum_out <= '0; route_out <= '0; table_full <= 1'b0;
      if (cmd.do_update) begin
        if (found) begin
          hit <= 1'b1;
          route_out <= rte_q;
          sum_out <= (act == chat_pkg::ACT_INSERT) ? sum_q + val : sum_q;
        end else if (act == chat_pkg::ACT_INSERT) begin
          if (count < EMAX) sum_out <= val;
          else              table_full <= 1'b1;
        end
      end
    end
  end

  // Status
  always_comb begin
    stat.act       = act;
    stat.hash_done = (kstep == SW'(KSTEPS));
    stat.clr_done  = (clr_idx == BW'(BUCKETS - 1));
    stat.walk_ok   = pos[EW] && (steps < count) &&
                     ({1'b0, pos[EW-1:0]} < EMAX);
    stat.key_match = (key_q == key) && stat.walk_ok;
  end

endmodule
